// File: sv/array_element_address_calc_core_assert.svh
// Assertion helpers shared by the address calculator modules.
`ifndef ARRAY_ELEMENT_ADDRESS_CALC_CORE_ASSERT_SVH
`define ARRAY_ELEMENT_ADDRESS_CALC_CORE_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define AEAC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define AEAC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: sv/aeac_pkg.sv
package aeac_pkg;

  // Input op codes as they arrive on tuser
  localparam logic [1:0] OP_HEADER = 2'd0;
  localparam logic [1:0] OP_BOUNDS = 2'd1;
  localparam logic [1:0] OP_INDEX  = 2'd2;

  localparam int unsigned CmdQueueDepth = 2;

  // Command kinds after classification
  typedef enum logic [1:0] {
    CMD_HDR,
    CMD_BND,
    CMD_IDX
  } cmd_op_e;

  // One classified command; val_b holds element size or extent
  typedef struct packed {
    cmd_op_e     op;
    logic [3:0]  id;
    logic [3:0]  dim;
    logic [31:0] val_a;
    logic [31:0] val_b;
    logic [4:0]  total;
  } cmd_t;

endpackage

// File: sv/aeac_ram.sv
module aeac_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/aeac_front.sv
module aeac_front import aeac_pkg::*; #(
  parameter int unsigned NUM_ARRAYS = 16,
  parameter int unsigned MAX_DIMS   = 16
) (
  input  logic [1:0]  op_i,
  input  logic [3:0]  array_id_i,
  input  logic [3:0]  dim_index_i,
  input  logic [31:0] first_value_i,
  input  logic [31:0] second_value_i,
  input  logic [4:0]  dim_total_i,
  output cmd_t        cmd_o,
  output logic        keep_o
);

  logic       id_ok;
  logic       dim_ok;
  logic [4:0] total;

  assign id_ok  = int'(array_id_i) < NUM_ARRAYS;
  assign dim_ok = int'(dim_index_i) < MAX_DIMS;

  // Clamp the dimension count into one to MAX_DIMS
  always_comb begin
    total = dim_total_i;
    if (dim_total_i == 5'd0) begin
      total = 5'd1;
    end else if (int'(dim_total_i) > MAX_DIMS) begin
      total = 5'(MAX_DIMS);
    end
  end

  // Classify the item and drop anything that changes nothing
  always_comb begin
    cmd_o.id    = array_id_i;
    cmd_o.dim   = dim_index_i;
    cmd_o.val_a = first_value_i;
    cmd_o.val_b = second_value_i;
    cmd_o.total = total;
    cmd_o.op    = CMD_IDX;
    keep_o      = 1'b0;
    case (op_i)
      OP_HEADER: begin
        cmd_o.op = CMD_HDR;
        keep_o   = id_ok;
      end
      OP_BOUNDS: begin
        cmd_o.op    = CMD_BND;
        cmd_o.val_b = second_value_i - first_value_i + 32'd1;
        keep_o      = id_ok && dim_ok;
      end
      OP_INDEX: begin
        cmd_o.op = CMD_IDX;
        keep_o   = id_ok && dim_ok;
      end
      default: begin
        keep_o = 1'b0;
      end
    endcase
  end

endmodule

// File: sv/aeac_fifo.sv
`include "array_element_address_calc_core_assert.svh"

module aeac_fifo import aeac_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t wdata_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t rdata_o,
  output logic valid_o
);

  localparam int unsigned PtrW = (CmdQueueDepth > 1) ? $clog2(CmdQueueDepth) : 1;
  localparam int unsigned CntW = $clog2(CmdQueueDepth + 1);

  cmd_t            mem_q [CmdQueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = count_q == CntW'(CmdQueueDepth);
  assign valid_o = count_q != '0;
  assign rdata_o = mem_q[rd_ptr_q];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (int'(wr_ptr_q) == CmdQueueDepth - 1) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (int'(rd_ptr_q) == CmdQueueDepth - 1) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  `AEAC_ASSERT_IMPL(a_pop_nonempty, clk_i, rst_ni, pop_i, count_q != '0, "pop from empty queue")
  `AEAC_ASSERT(a_count_bound, clk_i, rst_ni, int'(count_q) <= CmdQueueDepth, "queue overfilled")

endmodule

// File: sv/aeac_back.sv
`include "array_element_address_calc_core_assert.svh"

module aeac_back import aeac_pkg::*; #(
  parameter int unsigned NUM_ARRAYS = 16,
  parameter int unsigned MAX_DIMS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        cmd_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  out_id_o,
  output logic [31:0] out_addr_o
);

  localparam int unsigned SlotDepth = NUM_ARRAYS * MAX_DIMS;
  localparam int unsigned SlotW     = (SlotDepth > 1) ? $clog2(SlotDepth) : 1;
  localparam int unsigned HdrW      = (NUM_ARRAYS > 1) ? $clog2(NUM_ARRAYS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FOLD,
    ST_ADDR
  } state_e;

  state_e      st_q, st_d;
  cmd_t        cur_q, cur_d;
  logic [31:0] acc_q, acc_d;
  logic        out_valid_q, out_valid_d;
  logic [3:0]  out_id_q, out_id_d;
  logic [31:0] out_addr_q, out_addr_d;

  logic             hdr_we, bnd_we, rd_en;
  logic [SlotW-1:0] wr_slot, rd_slot;
  logic [68:0]      hdr_rdata;
  logic [63:0]      bnd_rdata;
  logic [31:0]      base, elem_size, lower, extent, offset;
  logic [4:0]       count;
  logic             out_free;

  // Flatten array and dimension into one descriptor slot
  assign wr_slot = SlotW'(int'(cmd_i.id) * MAX_DIMS + int'(cmd_i.dim));
  assign rd_slot = wr_slot;

  assign hdr_we = (st_q == ST_IDLE) && cmd_valid_i && (cmd_i.op == CMD_HDR);
  assign bnd_we = (st_q == ST_IDLE) && cmd_valid_i && (cmd_i.op == CMD_BND);
  assign rd_en  = (st_q == ST_IDLE) && cmd_valid_i && (cmd_i.op == CMD_IDX);
  assign cmd_pop_o = (st_q == ST_IDLE) && cmd_valid_i;

  // Header table: count, element size, base
  aeac_ram #(
    .Width (69),
    .Depth (NUM_ARRAYS),
    .AddrW (HdrW)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (hdr_we),
    .waddr_i (HdrW'(cmd_i.id)),
    .wdata_i ({cmd_i.total, cmd_i.val_b, cmd_i.val_a}),
    .re_i    (rd_en),
    .raddr_i (HdrW'(cmd_i.id)),
    .rdata_o (hdr_rdata)
  );

  // Bounds table: extent, lower bound
  aeac_ram #(
    .Width (64),
    .Depth (SlotDepth),
    .AddrW (SlotW)
  ) u_bnd_ram (
    .clk_i   (clk_i),
    .we_i    (bnd_we),
    .waddr_i (wr_slot),
    .wdata_i ({cmd_i.val_b, cmd_i.val_a}),
    .re_i    (rd_en),
    .raddr_i (rd_slot),
    .rdata_o (bnd_rdata)
  );

  assign base      = hdr_rdata[31:0];
  assign elem_size = hdr_rdata[63:32];
  assign count     = hdr_rdata[68:64];
  assign lower     = bnd_rdata[31:0];
  assign extent    = bnd_rdata[63:32];
  assign offset    = cur_q.val_a - lower;
  assign out_free  = !out_valid_q || out_ready_i;

  // Sequence one index item: capture, fold, then form the address if it closes a query
  always_comb begin
    st_d        = st_q;
    cur_d       = cur_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_id_d    = out_id_q;
    out_addr_d  = out_addr_q;
    case (st_q)
      ST_IDLE: begin
        if (rd_en) begin
          cur_d = cmd_i;
          st_d  = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (cur_q.dim == 4'd0) begin
          acc_d = offset;
        end else begin
          acc_d = acc_q * extent + offset;
        end
        st_d = ({1'b0, cur_q.dim} == count - 5'd1) ? ST_ADDR : ST_IDLE;
      end
      ST_ADDR: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_id_d    = cur_q.id;
          out_addr_d  = elem_size * acc_q + base;
          st_d        = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      cur_q       <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      out_id_q    <= '0;
      out_addr_q  <= '0;
    end else begin
      st_q        <= st_d;
      cur_q       <= cur_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
      out_id_q    <= out_id_d;
      out_addr_q  <= out_addr_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_id_o    = out_id_q;
  assign out_addr_o  = out_addr_q;

  `AEAC_ASSERT_IMPL(a_fold_after_idle, clk_i, rst_ni, st_q == ST_FOLD, $past(st_q) == ST_IDLE, "fold without capture")
  `AEAC_ASSERT_IMPL(a_addr_after_fold, clk_i, rst_ni, st_q == ST_ADDR, $past(st_q) == ST_FOLD || $past(st_q) == ST_ADDR, "address step out of order")
  `AEAC_ASSERT_IMPL(a_out_from_addr, clk_i, rst_ni, $rose(out_valid_q), $past(st_q) == ST_ADDR, "result without address step")

endmodule

// File: sv/array_element_address_calc_core.sv
// Row-major array address calculator. Header items (tuser 0) load an array's
// base, element size and dimension count; bounds items (tuser 1) load one
// dimension's lower bound and extent; index items (tuser 2) feed one index
// each, dimension 0 first, and the item on the array's last dimension yields
// element_size * acc + base, wrapped to 32 bits. Items with an out-of-range
// array id, bounds or index items with an out-of-range dimension, and tuser 3
// items are dropped. Header and bounds items are written while idle; an index
// item passes the descriptor RAM read, the accumulator multiply-add and, when
// it closes a query, the address step. A two-entry command queue sits between
// the input stage and the execution unit, and the result sits in an output
// register. While a result waits, the next index item that closes a query
// holds in the address step, and the input stops once the queue is full.
module array_element_address_calc_core import aeac_pkg::*; #(
  parameter int unsigned NUM_ARRAYS = 16,
  parameter int unsigned MAX_DIMS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // array_id[3:0], dim_index[7:4], first_value[39:8], second_value[71:40],
  // dim_total[76:72], zero fill[79:77]
  input  logic [79:0] s_axis_tdata_i,
  // op[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // result_array[3:0], address[35:4], zero fill[39:36]
  output logic [39:0] m_axis_tdata_o
);

  cmd_t        front_cmd, head_cmd;
  logic        keep, full, push, head_valid, pop;
  logic [3:0]  out_id;
  logic [31:0] out_addr;

  aeac_front #(
    .NUM_ARRAYS (NUM_ARRAYS),
    .MAX_DIMS   (MAX_DIMS)
  ) u_front (
    .op_i           (s_axis_tuser_i),
    .array_id_i     (s_axis_tdata_i[3:0]),
    .dim_index_i    (s_axis_tdata_i[7:4]),
    .first_value_i  (s_axis_tdata_i[39:8]),
    .second_value_i (s_axis_tdata_i[71:40]),
    .dim_total_i    (s_axis_tdata_i[76:72]),
    .cmd_o          (front_cmd),
    .keep_o         (keep)
  );

  // Queue every kept transfer
  assign s_axis_tready_o = !full;
  assign push = s_axis_tvalid_i && !full && keep;

  aeac_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (head_cmd),
    .valid_o (head_valid)
  );

  aeac_back #(
    .NUM_ARRAYS (NUM_ARRAYS),
    .MAX_DIMS   (MAX_DIMS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (head_valid),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_id_o    (out_id),
    .out_addr_o  (out_addr)
  );

  assign m_axis_tdata_o = {4'd0, out_addr, out_id};

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps

module tb;
  import aeac_pkg::*;

  localparam int unsigned N_ARRAYS    = 16;
  localparam int unsigned DIMS        = 16;
  localparam logic [1:0]  OP_NONE     = 2'd3;
  localparam int          RAND_ITEMS  = 1450;
  localparam int          DRAIN_EVERY = 400;
  localparam int          HOLD_AT     = 1500;
  localparam int          HOLD_LEN    = 300;
  localparam int          STALL_LIMIT = 2000;
  localparam int          TAIL_CYCLES = 20;

  typedef struct {
    logic [1:0]  op;
    logic [3:0]  array_id;
    logic [3:0]  dim_index;
    logic [31:0] first_value;
    logic [31:0] second_value;
    logic [4:0]  dim_total;
    bit          drain_first;
  } desc_item_t;

  typedef struct {
    logic [3:0]  result_array;
    logic [31:0] address;
  } elem_addr_t;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_MOSTLY} sink_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        hold_on = 1'b0;

  // Stimulus and expected addresses
  desc_item_t item_q[$];
  elem_addr_t addr_expected_q[$];

  // Predictor copy of the descriptor tables
  logic [31:0] base_mem [N_ARRAYS];
  logic [31:0] esize_mem [N_ARRAYS];
  logic [4:0]  dcount_mem [N_ARRAYS];
  logic [31:0] lower_mem [N_ARRAYS][DIMS];
  logic [31:0] extent_mem [N_ARRAYS][DIMS];
  logic [31:0] horner_acc = '0;

  // Generator bookkeeping: which entries are written, current dimension counts
  bit hdr_ok [N_ARRAYS];
  bit bnd_ok [N_ARRAYS][DIMS];
  int gen_cnt [N_ARRAYS];
  bit drain_next = 1'b0;
  int n_gen = 0;

  int n_accepted = 0;
  int n_index_items = 0;
  int n_headers = 0;
  int results_predicted = 0;
  int results_seen = 0;
  int n_err = 0;

  int burst_left = 0;
  int gap_left = 0;
  int sink_cycles = 0;
  int mode_left = 0;
  sink_mode_e sink_mode = SINK_OPEN;

  always #5 clk_i = ~clk_i;

  array_element_address_calc_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  // Apply one accepted item to the descriptor tables and the Horner
  // accumulator; queue the element address when a query closes
  function automatic void fold_descriptor_item(input desc_item_t it);
    logic [31:0] off;
    logic [4:0]  tot;
    elem_addr_t  r;
    case (it.op)
      OP_HEADER: begin
        tot = it.dim_total;
        if (tot == 5'd0) tot = 5'd1;
        if (tot > DIMS) tot = 5'(DIMS);
        base_mem[it.array_id]   = it.first_value;
        esize_mem[it.array_id]  = it.second_value;
        dcount_mem[it.array_id] = tot;
        n_headers++;
      end
      OP_BOUNDS: begin
        lower_mem[it.array_id][it.dim_index]  = it.first_value;
        extent_mem[it.array_id][it.dim_index] = it.second_value - it.first_value + 32'd1;
      end
      OP_INDEX: begin
        n_index_items++;
        off = it.first_value - lower_mem[it.array_id][it.dim_index];
        if (it.dim_index == 4'd0)
          horner_acc = off;
        else
          horner_acc = horner_acc * extent_mem[it.array_id][it.dim_index] + off;
        if ({1'b0, it.dim_index} == dcount_mem[it.array_id] - 5'd1) begin
          r.result_array = it.array_id;
          r.address      = esize_mem[it.array_id] * horner_acc + base_mem[it.array_id];
          addr_expected_q.push_back(r);
          results_predicted++;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 6))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      4: return $urandom_range(0, 64) - 32;
      default: return $urandom();
    endcase
  endfunction

  function automatic bit array_ready(input int id);
    bit ok;
    ok = hdr_ok[id];
    for (int d = 0; d < gen_cnt[id]; d++)
      if (!bnd_ok[id][d]) ok = 1'b0;
    return ok;
  endfunction

  task automatic push_item(input logic [1:0] op, input logic [3:0] id, input logic [3:0] dim,
                           input logic [31:0] v1, input logic [31:0] v2,
                           input logic [4:0] tot);
    desc_item_t it;
    it.op           = op;
    it.array_id     = id;
    it.dim_index    = dim;
    it.first_value  = v1;
    it.second_value = v2;
    it.dim_total    = tot;
    it.drain_first  = drain_next;
    drain_next      = 1'b0;
    item_q.push_back(it);
    case (op)
      OP_HEADER: begin
        hdr_ok[id]  = 1'b1;
        gen_cnt[id] = (tot == 0) ? 1 : ((tot > DIMS) ? DIMS : tot);
        n_gen++;
      end
      OP_BOUNDS: begin
        bnd_ok[id][dim] = 1'b1;
        n_gen++;
      end
      OP_INDEX: n_gen++;
      default: ;
    endcase
  endtask

  // Load a header with a random dimension count, then bounds for every dimension
  task automatic define_array(input int id);
    int sel;
    int raw;
    logic [31:0] lo;
    sel = $urandom_range(0, 19);
    if (sel < 14)
      raw = $urandom_range(1, 4);
    else if (sel < 17)
      raw = $urandom_range(5, 16);
    else
      raw = $urandom_range(0, 31);
    push_item(OP_HEADER, 4'(id), 4'($urandom_range(0, 15)), rand_word(), rand_word(),
              5'(raw));
    for (int d = 0; d < gen_cnt[id]; d++) begin
      lo = rand_word();
      push_item(OP_BOUNDS, 4'(id), 4'(d), lo,
                $urandom_range(0, 1) ? lo + $urandom_range(0, 9) : rand_word(),
                5'($urandom_range(0, 31)));
    end
  endtask

  task automatic run_query(input int id, input int upto);
    for (int d = 0; d < upto; d++)
      push_item(OP_INDEX, 4'(id), 4'(d), rand_word(), $urandom(),
                5'($urandom_range(0, 31)));
  endtask

  // Driver: bursts with random gaps, drain pauses, no gaps while the sink holds off
  always @(posedge clk_i) begin : drive_p
    bit accepted;
    bit offer;
    desc_item_t nxt;
    if (rst_ni) begin
      accepted = s_tvalid && s_tready;
      if (accepted) begin
        fold_descriptor_item(nxt);
        n_accepted++;
      end
      if (!s_tvalid || accepted) begin
        offer = 1'b0;
        if (gap_left > 0 && !hold_on)
          gap_left--;
        else if (item_q.size() != 0)
          offer = !(item_q[0].drain_first && results_seen < results_predicted);
        if (offer) begin
          nxt = item_q.pop_front();
          s_tdata <= {3'b000, nxt.dim_total, nxt.second_value, nxt.first_value,
                      nxt.dim_index, nxt.array_id};
          s_tuser <= nxt.op;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
          end
        end
        s_tvalid <= offer;
      end
    end
  end

  // Sink: changing stall patterns plus one long hold-off
  always @(posedge clk_i) begin : sink_p
    bit rdy;
    bit hold;
    if (rst_ni) begin
      sink_cycles++;
      hold = (sink_cycles >= HOLD_AT) && (sink_cycles < HOLD_AT + HOLD_LEN);
      if (hold) begin
        rdy = 1'b0;
      end else begin
        if (mode_left == 0) begin
          sink_mode = sink_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(32, 256);
        end else begin
          mode_left--;
        end
        case (sink_mode)
          SINK_OPEN:   rdy = 1'b1;
          SINK_COIN:   rdy = 1'($urandom_range(0, 1));
          SINK_SPARSE: rdy = (sink_cycles % 4 == 0);
          default:     rdy = ($urandom_range(0, 3) != 0);
        endcase
      end
      m_tready <= rdy;
      hold_on  <= hold;
    end
  end

  // Monitor: compare each result transfer with the oldest expected address
  always @(posedge clk_i) begin : check_p
    elem_addr_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (addr_expected_q.size() == 0) begin
        $error("unexpected result: result_array %0d address %08h",
               m_tdata[3:0], m_tdata[35:4]);
        n_err++;
      end else begin
        want = addr_expected_q.pop_front();
        if (m_tdata[3:0] !== want.result_array) begin
          $error("result_array mismatch: expected %0d, actual %0d",
                 want.result_array, m_tdata[3:0]);
          n_err++;
        end
        if (m_tdata[35:4] !== want.address) begin
          $error("address mismatch: expected %08h, actual %08h",
                 want.address, m_tdata[35:4]);
          n_err++;
        end
      end
      results_seen <= results_seen + 1;
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin : watchdog_p
    int idle;
    idle = 0;
    @(posedge rst_ni);
    while (idle < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        idle = 0;
      else
        idle++;
    end
    $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : main_p
    int act;
    int id;
    int d;
    int next_drain;

    // Directed: extremes, clamped counts, unused op, index past the count,
    // shared accumulator across arrays
    push_item(OP_HEADER, 4'd0, 4'd9, 32'h0000_1000, 32'd4, 5'd2);
    push_item(OP_BOUNDS, 4'd0, 4'd0, -32'sd5, 32'sd5, 5'd0);
    push_item(OP_BOUNDS, 4'd0, 4'd1, 32'd10, 32'd19, 5'd31);
    push_item(OP_INDEX,  4'd0, 4'd0, 32'd3, 32'hFFFF_FFFF, 5'd0);
    push_item(OP_INDEX,  4'd0, 4'd1, 32'd12, 32'h0, 5'd31);
    push_item(OP_HEADER, 4'd15, 4'd15, 32'hFFFF_FFFF, 32'h8000_0000, 5'd0);
    push_item(OP_BOUNDS, 4'd15, 4'd0, 32'h7FFF_FFFF, 32'h8000_0000, 5'd0);
    push_item(OP_INDEX,  4'd15, 4'd0, 32'h8000_0000, 32'h7FFF_FFFF, 5'd16);
    push_item(OP_NONE,   4'd15, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
    push_item(OP_NONE,   4'd0, 4'd0, 32'h0, 32'h0, 5'd0);
    push_item(OP_HEADER, 4'd7, 4'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 5'd31);
    push_item(OP_BOUNDS, 4'd0, 4'd15, 32'h8000_0000, 32'h7FFF_FFFF, 5'd0);
    push_item(OP_INDEX,  4'd0, 4'd15, 32'h0, 32'h0, 5'd0);
    push_item(OP_INDEX,  4'd0, 4'd1, 32'hFFFF_FFFF, 32'h0, 5'd0);
    push_item(OP_HEADER, 4'd7, 4'd3, 32'h8000_0000, 32'hFFFF_FFFF, 5'd17);
    push_item(OP_HEADER, 4'd7, 4'd3, 32'h8000_0000, 32'hFFFF_FFFF, 5'd1);
    push_item(OP_BOUNDS, 4'd7, 4'd0, 32'h0, 32'h0, 5'd0);
    push_item(OP_INDEX,  4'd7, 4'd0, 32'h7FFF_FFFF, 32'h0, 5'd0);
    push_item(OP_INDEX,  4'd0, 4'd0, -32'sd5, 32'h0, 5'd0);
    push_item(OP_INDEX,  4'd7, 4'd0, 32'h8000_0000, 32'h0, 5'd0);
    push_item(OP_INDEX,  4'd0, 4'd1, 32'd19, 32'h0, 5'd0);

    // Random: mostly well-formed queries, with redefinitions and noise
    n_gen      = 0;
    drain_next = 1'b1;
    next_drain = DRAIN_EVERY;
    while (n_gen < RAND_ITEMS) begin
      if (n_gen >= next_drain) begin
        drain_next = 1'b1;
        next_drain += DRAIN_EVERY;
      end
      act = $urandom_range(0, 99);
      id  = $urandom_range(0, N_ARRAYS - 1);
      if (act < 8 || !array_ready(id)) begin
        define_array(id);
      end else if (act < 75) begin
        run_query(id, gen_cnt[id]);
      end else if (act < 82) begin
        // broken-off query
        run_query(id, $urandom_range(1, gen_cnt[id]));
      end else if (act < 88) begin
        d = $urandom_range(0, DIMS - 1);
        push_item(OP_BOUNDS, 4'(id), 4'(d), rand_word(), rand_word(),
                  5'($urandom_range(0, 31)));
      end else if (act < 94) begin
        // any written dimension, often past the array's count
        d = $urandom_range(0, DIMS - 1);
        if (bnd_ok[id][d])
          push_item(OP_INDEX, 4'(id), 4'(d), rand_word(), $urandom(),
                    5'($urandom_range(0, 31)));
      end else begin
        push_item(OP_NONE, 4'(id), 4'($urandom_range(0, 15)), $urandom(), $urandom(),
                  5'($urandom_range(0, 31)));
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: all stimulus sent, every expected address seen, then a short tail
    while (item_q.size() != 0 || s_tvalid || results_seen < results_predicted)
      @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Run covered %0d items: %0d index items, %0d header loads, %0d addresses checked.",
             n_accepted, n_index_items, n_headers, results_seen);
    $display("Included clamped dimension counts, unused ops, out-of-order indices, long stall.");
    if (n_err == 0 && addr_expected_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
